[src/rtws_pkg.sv]
// ----------------------------------------------------------------------------
// rtws_pkg
// shared types, constants and the colour-bit to spi-bit expansion for the
// ws2812 spi bitstream encoder
// ----------------------------------------------------------------------------
package rtws_pkg;

  localparam int ColourBits   = 24;
  localparam int SpiPerBit    = 9;
  localparam int PixSpiBits   = ColourBits * SpiPerBit;  // 216
  localparam int PixBytes     = PixSpiBits / 8;          // 27
  localparam int GapW         = 10;
  localparam int CntW         = $clog2(PixBytes);

  localparam logic [GapW-1:0]      GapReset = GapW'(350);
  localparam logic [SpiPerBit-1:0] PatZero  = 9'b111000000;
  localparam logic [SpiPerBit-1:0] PatOne   = 9'b111111000;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_EOF   = 1'b1
  } action_e;

  // one queued item: what to do and the colour word already in grb order
  typedef struct packed {
    action_e               action;
    logic [ColourBits-1:0] grb;
  } entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // each colour bit, msb first, becomes one nine-bit pulse pattern
  function automatic logic [PixSpiBits-1:0] expand(logic [ColourBits-1:0] grb);
    logic [PixSpiBits-1:0] bits;
    bits = '0;
    for (int i = 0; i < ColourBits; i++) begin
      bits[i*SpiPerBit +: SpiPerBit] = grb[i] ? PatOne : PatZero;
    end
    return bits;
  endfunction

endpackage

[src/rtws_front.sv]
// ----------------------------------------------------------------------------
// rtws_front
// accepts items, classifies them and reorders colour to grb, then holds
// them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module rtws_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output rtws_pkg::head_t     head_o,
  input  logic                pop_i
);

  rtws_pkg::entry_t mem_q [2];
  rtws_pkg::entry_t wr_entry;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  logic             pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_entry.action = action_i ? rtws_pkg::ACT_EOF : rtws_pkg::ACT_PIXEL;
    wr_entry.grb    = {green_i, red_i, blue_i};
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

[src/rtws_back.sv]
// ----------------------------------------------------------------------------
// rtws_back
// expands the queued colour word into 216 spi bits and sends them as 27
// bytes, or sends one zero byte with the gap count at end of frame
// ----------------------------------------------------------------------------
module rtws_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rtws_pkg::GapW-1:0]   gap_i,
  input  rtws_pkg::head_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  spi_byte_o,
  output logic [rtws_pkg::GapW-1:0]   repeat_count_o,
  output logic                        last_of_run_o
);

  localparam int RestW = rtws_pkg::PixSpiBits - 8;

  logic                       active_q, active_d;
  logic [RestW-1:0]           sr_q, sr_d;
  logic [rtws_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 byte_q, byte_d;
  logic [rtws_pkg::GapW-1:0]  rep_q, rep_d;
  logic                       last_q, last_d;
  logic                       adv;
  logic                       emit;
  logic [rtws_pkg::PixSpiBits-1:0] exp_bits;
  logic [rtws_pkg::GapW-1:0]  gap_sat;

  assign adv      = !out_valid_q || out_ready_i;
  assign exp_bits = rtws_pkg::expand(head_i.entry.grb);
  // a zero gap still sends one byte
  assign gap_sat  = (gap_i == '0) ? rtws_pkg::GapW'(1) : gap_i;

  always_comb begin
    active_d = active_q;
    sr_d     = sr_q;
    cnt_d    = cnt_q;
    byte_d   = byte_q;
    rep_d    = rep_q;
    last_d   = last_q;
    emit     = 1'b0;
    pop_o    = 1'b0;
    if (adv) begin
      if (active_q) begin
        emit     = 1'b1;
        byte_d   = sr_q[RestW-1 -: 8];
        rep_d    = rtws_pkg::GapW'(1);
        last_d   = (cnt_q == rtws_pkg::CntW'(1));
        sr_d     = {sr_q[RestW-9:0], 8'h00};
        cnt_d    = cnt_q - rtws_pkg::CntW'(1);
        active_d = (cnt_q != rtws_pkg::CntW'(1));
      end else if (head_i.valid) begin
        emit  = 1'b1;
        pop_o = 1'b1;
        if (head_i.entry.action == rtws_pkg::ACT_EOF) begin
          byte_d = 8'h00;
          rep_d  = gap_sat;
          last_d = 1'b1;
        end else begin
          // first byte goes out now, the other 26 are shifted out next
          byte_d   = exp_bits[rtws_pkg::PixSpiBits-1 -: 8];
          rep_d    = rtws_pkg::GapW'(1);
          last_d   = 1'b0;
          sr_d     = exp_bits[RestW-1:0];
          cnt_d    = rtws_pkg::CntW'(rtws_pkg::PixBytes - 1);
          active_d = 1'b1;
        end
      end
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    byte_q <= byte_d;
    rep_q  <= rep_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign spi_byte_o     = byte_q;
  assign repeat_count_o = rep_q;
  assign last_of_run_o  = last_q;

endmodule

[src/rgb_to_ws2812_spi_bitstream_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_ws2812_spi_bitstream_top
// rgb pixel to ws2812 spi byte stream encoder with end-of-frame reset gap
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid_i/in_ready_o  | action_i, red_i, green_i, blue_i
//  out      | out_valid_o/out_ready_i| spi_byte_o, repeat_count_o,
//           |                        | last_of_run_o
//  cfg      | cfg_we_i               | cfg_wdata_i (reset_gap_bytes)
//
// a pixel gives 27 bytes, one per cycle from the back end's shift register
// while out_ready_i is high; end of frame gives one byte. items queue two
// deep between front and back, and an accepted item passes through the
// queue register and then the output register. reset clears the queue and
// output valid and sets the gap register to 350. out stalls hold the output
// register and back the queue up into in_ready_o.
module rgb_to_ws2812_spi_bitstream_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rtws_pkg::GapW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 spi_byte_o,
  output logic [rtws_pkg::GapW-1:0]  repeat_count_o,
  output logic                       last_of_run_o
);

  logic [rtws_pkg::GapW-1:0] gap_q, gap_d;
  rtws_pkg::head_t           head;
  logic                      pop;

  assign gap_d = cfg_we_i ? cfg_wdata_i : gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= rtws_pkg::GapReset;
    end else begin
      gap_q <= gap_d;
    end
  end

  rtws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  rtws_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .gap_i          (gap_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .spi_byte_o     (spi_byte_o),
    .repeat_count_o (repeat_count_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
